>>> hw/rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared constants and controller/datapath interface types for the LRU
// block buffer directory.
// ----------------------------------------------------------------------------
package lbd_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int TAG_W     = 16;
    localparam int OUTCOME_W = 2;
    localparam int SLOT_W    = 4;
    localparam int RANK_W    = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USED_W = OUTCOME_W + SLOT_W + RANK_W;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FETCH = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/lru_block_buffer_directory.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_directory
// Fully associative, most-recently-used ordered directory of a disk block
// buffer cache.
// ----------------------------------------------------------------------------
// Each block number taken on the input stream is compared in parallel against
// all live entries in the transfer cycle and the match vector is registered;
// once the output register is free, the first match (or a new entry, while
// room remains) moves to the front of the order and the result is loaded into
// the output register. The next lookup depends on that recency shift, so the
// input is ready again only once the result has been loaded. A hit reports
// its slot and prior rank, a miss with room takes slot number equal to the
// current fill count, and a miss when full reports full and leaves the
// directory unchanged. No clearing pass is needed after reset.
module lru_block_buffer_directory #(
    parameter int ENTRIES = lbd_pkg::DEF_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: block_number[15:0].
    input  logic [lbd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: outcome[1:0], slot[5:2], prior_rank[9:6], zero fill.
    output logic [lbd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    lbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lbd_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_tag       (s_axis_tdata[TAG_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/lbd_ctrl.sv
// ----------------------------------------------------------------------------
// lbd_ctrl
// Sequencer: takes one lookup, then commits the directory update and the
// result once the output register can take it.
// ----------------------------------------------------------------------------
module lbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lbd_pkg::t_status i_status,
    output lbd_pkg::t_cmd    o_cmd
);
    import lbd_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/lbd_dpath.sv
// ----------------------------------------------------------------------------
// lbd_dpath
// Recency-ordered tag and slot rows, parallel tag compare, move-to-front
// shift and the result register.
// ----------------------------------------------------------------------------
module lbd_dpath #(
    parameter int ENTRIES = lbd_pkg::DEF_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lbd_pkg::t_cmd                  i_cmd,
    output lbd_pkg::t_status               o_status,
    input  logic [lbd_pkg::TAG_W-1:0]      i_tag,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [lbd_pkg::OUT_DATA_W-1:0] o_out_data
);
    import lbd_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [TAG_W-1:0]   r_tags  [ENTRIES];
    logic [SLOT_W-1:0]  r_slots [ENTRIES];
    logic [CNT_W-1:0]   r_used;
    logic [TAG_W-1:0]   r_tag;
    logic [ENTRIES-1:0] r_match;
    logic               r_out_valid;
    logic [OUT_USED_W-1:0] r_out;

    logic [ENTRIES-1:0] n_match;
    logic               hit;
    logic               full;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   upto;
    logic [SLOT_W-1:0]  front_slot;
    logic               do_place;
    logic [OUTCOME_W-1:0] outcome;
    logic [RANK_W-1:0]  rank;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i] = (r_tags[i] == i_tag) && (CNT_W'(i) < r_used);
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit  = |r_match;
    assign full = (r_used == CNT_W'(ENTRIES));

    always_comb begin
        upto       = r_used[IDX_W-1:0];
        front_slot = SLOT_W'(r_used);
        outcome    = OUTCOME_FETCH;
        rank       = '0;
        do_place   = 1'b1;
        if (hit) begin
            upto       = hit_idx;
            front_slot = r_slots[hit_idx];
            outcome    = OUTCOME_HIT;
            rank       = RANK_W'(hit_idx);
        end else if (full) begin
            front_slot = '0;
            outcome    = OUTCOME_FULL;
            do_place   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tag   <= i_tag;
            r_match <= n_match;
        end
        if (i_cmd.commit && do_place) begin
            for (int j = 1; j < ENTRIES; j++) begin
                if (IDX_W'(j) <= upto) begin
                    r_tags[j]  <= r_tags[j-1];
                    r_slots[j] <= r_slots[j-1];
                end
            end
            r_tags[0]  <= r_tag;
            r_slots[0] <= front_slot;
        end
        if (i_cmd.commit) begin
            r_out <= {rank, front_slot, outcome};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && !hit && !full) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = OUT_DATA_W'(r_out);

endmodule

>>> hw/rtl/lbd_checker.sv
// ----------------------------------------------------------------------------
// lbd_checker
// Port-level checks of the LRU block buffer directory, bound to the top level.
// ----------------------------------------------------------------------------
module lbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [lbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import lbd_pkg::*;

    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
    logic [RANK_W-1:0]    rank;

    assign outcome = m_axis_tdata[OUTCOME_W-1:0];
    assign slot    = m_axis_tdata[OUTCOME_W+SLOT_W-1:OUTCOME_W];
    assign rank    = m_axis_tdata[OUT_USED_W-1:OUTCOME_W+SLOT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while a lookup was still in progress.");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (outcome == OUTCOME_HIT || outcome == OUTCOME_FETCH ||
                           outcome == OUTCOME_FULL))
        else $error("Result carries an unknown outcome.");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && outcome != OUTCOME_HIT |->
            rank == '0 && (outcome != OUTCOME_FULL || slot == '0))
        else $error("Miss result carries a nonzero rank or full result a slot.");

endmodule

bind lru_block_buffer_directory lbd_checker u_lbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

>>> tb/lru_block_buffer_directory_test.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_directory_test
// Self-checking testbench for the LRU block buffer directory. A queue of
// block requests fills the directory, covers hits at the front and back of
// the recency order and misses once it is full, then runs random accesses
// that are mostly hits. Each accepted request is run through a recency-list
// model, and every result transfer is checked against the oldest prediction.
// Both stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module lru_block_buffer_directory_test;

    import lbd_pkg::*;

    localparam int ENTRIES    = DEF_ENTRIES;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_CNT = 930;

    typedef struct packed {
        logic [RANK_W-1:0]    rank;
        logic [SLOT_W-1:0]    slot;
        logic [OUTCOME_W-1:0] outcome;
    } t_lookup_result;

    typedef struct {
        logic [TAG_W-1:0] tag;
        bit               hold;
    } t_block_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Fields from bit 0: block_number[15:0].
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // Fields from bit 0: outcome[1:0], slot[5:2], prior_rank[9:6], zero fill.
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_block_req       req_q[$];
    t_lookup_result   lookup_q[$];
    logic [TAG_W-1:0] mru_tag[ENTRIES];
    logic [SLOT_W-1:0] mru_slot[ENTRIES];
    int               live_cnt = 0;
    int               accepted_cnt = 0;
    int               request_total = 0;
    int               error_cnt = 0;
    int               idle_cycles = 0;
    bit               req_taken = 1'b0;
    int               send_gap = 0;
    int               stall_left = 0;
    bit               send_quiet = 1'b0;
    bit               recv_quiet = 1'b0;

    lru_block_buffer_directory #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic move_to_front(input int upto, input logic [TAG_W-1:0] tag,
                                 input logic [SLOT_W-1:0] slot);
        int k;
        if (upto > ENTRIES - 1) begin
            upto = ENTRIES - 1;
        end
        for (k = upto; k > 0; k--) begin
            mru_tag[k]  = mru_tag[k-1];
            mru_slot[k] = mru_slot[k-1];
        end
        mru_tag[0]  = tag;
        mru_slot[0] = slot;
    endtask

    task automatic predict_lookup(input logic [TAG_W-1:0] tag);
        t_lookup_result r;
        int             hit_at;
        int             k;
        hit_at = -1;
        for (k = 0; k < live_cnt; k++) begin
            if (hit_at < 0 && mru_tag[k] == tag) begin
                hit_at = k;
            end
        end
        if (hit_at >= 0) begin
            r.outcome = OUTCOME_HIT;
            r.slot    = mru_slot[hit_at];
            r.rank    = RANK_W'(hit_at);
            move_to_front(hit_at, tag, r.slot);
        end else if (live_cnt < ENTRIES) begin
            r.outcome = OUTCOME_FETCH;
            r.slot    = SLOT_W'(live_cnt);
            r.rank    = '0;
            move_to_front(live_cnt, tag, r.slot);
            live_cnt++;
        end else begin
            r.outcome = OUTCOME_FULL;
            r.slot    = '0;
            r.rank    = '0;
        end
        lookup_q.push_back(r);
    endtask

    task automatic queue_request(input logic [TAG_W-1:0] tag, input bit hold);
        t_block_req q;
        q.tag  = tag;
        q.hold = hold;
        req_q.push_back(q);
    endtask

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            req_taken = 1'b0;
            if ($urandom_range(0, 63) == 0) begin
                send_quiet = !send_quiet;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() != 0 && !(req_q[0].hold && lookup_q.size() != 0)) begin
                s_axis_tdata  <= req_q[0].tag;
                s_axis_tvalid <= 1'b1;
                void'(req_q.pop_front());
                send_gap = pick_gap(send_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) begin
                recv_quiet = !recv_quiet;
            end
            m_axis_tready <= 1'b1;
            stall_left = pick_gap(recv_quiet);
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge i_clk) begin
        t_lookup_result want;
        t_lookup_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_lookup(s_axis_tdata[TAG_W-1:0]);
                accepted_cnt++;
                req_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_USED_W-1:0];
                if (lookup_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none actual %h",
                             $time, m_axis_tdata);
                    error_cnt++;
                end else begin
                    want = lookup_q.pop_front();
                    if (got.outcome !== want.outcome) begin
                        $display("%0t: outcome expected %0d actual %0d",
                                 $time, want.outcome, got.outcome);
                        error_cnt++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                        error_cnt++;
                    end
                    if (got.rank !== want.rank) begin
                        $display("%0t: prior_rank expected %0d actual %0d",
                                 $time, want.rank, got.rank);
                        error_cnt++;
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] !== '0) begin
                        $display("%0t: fill bits expected 0 actual %h",
                                 $time, m_axis_tdata[OUT_DATA_W-1:OUT_USED_W]);
                        error_cnt++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("[lru_block_buffer_directory] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [TAG_W-1:0] known[$];
        logic [TAG_W-1:0] tag;
        int               n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        // Fill the directory with both extreme block numbers, hit at the
        // front and one step back, then overflow it and hit its oldest entry.
        queue_request(16'h0000, 1'b0);
        queue_request(16'h0000, 1'b0);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'h0000, 1'b0);
        known.push_back(16'h0000);
        known.push_back(16'hFFFF);
        for (n = 0; n < ENTRIES - 2; n++) begin
            tag = TAG_W'(16'h8000 ^ (16'h1111 * n) ^ 16'h0005);
            queue_request(tag, n == 6);
            known.push_back(tag);
        end
        queue_request(16'h7FFF, 1'b0);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'hFFFF, 1'b0);
        queue_request(known[0], 1'b0);

        // With the directory full, most accesses hit a live block at a
        // random depth; the rest are near or random block numbers that must report full when they miss.
        for (n = 0; n < RANDOM_CNT; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                tag = known[$urandom_range(0, ENTRIES - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
                tag = known[$urandom_range(0, ENTRIES - 1)] ^ (16'h1 << $urandom_range(0, 15));
            end else begin
                tag = TAG_W'($urandom_range(0, 16'hFFFF));
            end
            queue_request(tag, $urandom_range(0, 149) == 0);
        end
        request_total = req_q.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted_cnt < request_total || lookup_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);

        if (error_cnt == 0) begin
            $display("[lru_block_buffer_directory] OK");
        end else begin
            $display("[lru_block_buffer_directory] ERROR");
        end
        $finish;
    end

endmodule
